>>> src/slca_pkg.sv
// ----------------------------------------------------------------------------
// slca_pkg: shared types and constants of the sector LED colour averager
// Payload layout, operation and register codes, and the gamma 2.7 table.
// ----------------------------------------------------------------------------
package slca_pkg;

  localparam int unsigned BIN_W       = 12;
  localparam int unsigned PIX_W       = 24;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned PROD_W      = 2 * CH_W;

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CFG_BRIGHTNESS = 1'b0,
    CFG_GAMMA_EN   = 1'b1
  } cfg_idx_e;

  localparam logic [CH_W-1:0] BRIGHTNESS_RST = 8'd255;

  typedef logic [CH_W-1:0] gamma_tbl_t [256];

  // Entry i is the largest k with 255*(i/255)^2.7 >= k - 0.5, tested exactly as
  // (2k-1)^10 * 255^17 <= 1024 * i^27 in wide integers at elaboration.
  function automatic gamma_tbl_t gamma_build();
    gamma_tbl_t   tbl;
    logic [239:0] scale;
    logic [239:0] lhs;
    logic [239:0] rhs;
    logic [239:0] base;
    int unsigned  k;
    bit           stop;
    scale = 240'd1;
    for (int j = 0; j < 17; j++) begin
      scale = scale * 240'd255;
    end
    k = 0;
    for (int i = 0; i < 256; i++) begin
      rhs = 240'd1024;
      for (int j = 0; j < 27; j++) begin
        rhs = rhs * 240'(i);
      end
      stop = 1'b0;
      for (int s = 0; s < 256; s++) begin
        if (!stop && k < 255) begin
          base = 240'(2 * k + 1);
          lhs  = base;
          for (int j = 0; j < 9; j++) begin
            lhs = lhs * base;
          end
          lhs = lhs * scale;
          if (lhs <= rhs) begin
            k = k + 1;
          end else begin
            stop = 1'b1;
          end
        end
      end
      tbl[i] = 8'(k);
    end
    return tbl;
  endfunction

  localparam gamma_tbl_t GAMMA_TABLE = gamma_build();

endpackage

>>> src/slca_div.sv
// ----------------------------------------------------------------------------
// slca_div: three-channel restoring divider
// Divides the blue, green and red sums by the pixel count, one quotient bit
// per cycle. The sums never exceed 255 times the count, so eight bits suffice.
// ----------------------------------------------------------------------------
module slca_div
  import slca_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [NUM_CH-1:0][CH_W+COUNT_BITS-1:0]    sum_i,
  input  logic [COUNT_BITS-1:0]                     den_i,
  output logic                                      done_o,
  output logic [NUM_CH-1:0][CH_W-1:0]               quo_o
);

  localparam int unsigned SUM_W  = CH_W + COUNT_BITS;
  localparam int unsigned STEP_W = $clog2(CH_W);

  logic [NUM_CH-1:0][SUM_W-1:0] rem_q, rem_d;
  logic [NUM_CH-1:0][CH_W-1:0]  quo_q, quo_d;
  logic [COUNT_BITS-1:0]        den_q;
  logic [STEP_W-1:0]            step_q;
  logic                         busy_q, done_q;
  logic [SUM_W-1:0]             trial;

  always_comb begin
    trial = SUM_W'(den_q) << step_q;
    for (int c = 0; c < NUM_CH; c++) begin
      if (rem_q[c] >= trial) begin
        rem_d[c] = rem_q[c] - trial;
        quo_d[c] = {quo_q[c][CH_W-2:0], 1'b1};
      end else begin
        rem_d[c] = rem_q[c];
        quo_d[c] = {quo_q[c][CH_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= (step_q != '0);
      done_q <= (step_q == '0);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= sum_i;
      den_q  <= den_i;
      step_q <= STEP_W'(CH_W - 1);
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      step_q <= step_q - STEP_W'(1);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a division in flight");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

endmodule

>>> src/sector_led_color_averager_unit.sv
// ----------------------------------------------------------------------------
// Accumulates: one request per cycle back to back, written in the cycle after
// acceptance. Emit: after acceptance the bin is read (MOD), divided (DIV), gamma and
// brightness multiplied (SHADE) and scaled by 1/255 (SCALE); input held off until the
// result is staged. After reset a clearing pass writes every bin once, input held off.
// ----------------------------------------------------------------------------
module sector_led_color_averager_unit
  import slca_pkg::*;
#(
  parameter int unsigned BINS       = 4096,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // request stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // bin_index[11:0], pixel[35:12], zeros
  input  logic                   s_axis_tuser_i,  // op
  // result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // blue_out[7:0], green_out[15:8], red_out[23:16]
  output logic                   m_axis_tuser_o   // had_pixels
);

  localparam int unsigned SUM_W = CH_W + COUNT_BITS;
  localparam int unsigned AW    = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned MW    = NUM_CH * SUM_W + COUNT_BITS;
  localparam int unsigned RNG_W = 17;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SHADE = 3'd4;
  localparam logic [2:0] ST_SCALE = 3'd5;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    clr_addr_q;
  logic [CH_W-1:0]  brightness_q;
  logic             gamma_en_q;

  // request fields
  logic [BIN_W-1:0] s_bin;
  logic [PIX_W-1:0] s_pix;
  logic             accept;

  op_e              op_q;
  logic [AW-1:0]    addr_q;
  logic             inr_q;
  logic [PIX_W-1:0] pix_q;

  // bin store
  logic [MW-1:0]    mem_q [BINS];
  logic [MW-1:0]    mem_rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [MW-1:0]    mem_wdata;
  logic             fwd_q;
  logic [MW-1:0]    fwd_data_q;

  logic [MW-1:0]                entry;
  logic [COUNT_BITS-1:0]        cnt;
  logic [NUM_CH-1:0][SUM_W-1:0] sums;
  logic [NUM_CH-1:0][SUM_W-1:0] acc_sums;
  logic [NUM_CH-1:0][CH_W-1:0]  pix_ch;

  logic                         div_start, div_done;
  logic [NUM_CH-1:0][CH_W-1:0]  quo;
  logic                         had_q;
  logic [NUM_CH-1:0][PROD_W-1:0] prod_q, prod_d;
  logic [NUM_CH-1:0][CH_W-1:0]  scaled;

  logic                         m_valid_q;
  logic [OUT_TDATA_W-1:0]       m_tdata_q;
  logic                         m_tuser_q;
  logic                         out_load;

  assign s_bin = s_axis_tdata_i[BIN_W-1:0];
  assign s_pix = s_axis_tdata_i[BIN_W +: PIX_W];

  assign s_axis_tready_o = (state_q == ST_IDLE) || ((state_q == ST_MOD) && (op_q == OP_ACC));
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BRIGHTNESS_RST;
      gamma_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_BRIGHTNESS: brightness_q <= cfg_wdata_i;
        CFG_GAMMA_EN:   gamma_en_q   <= cfg_wdata_i[0];
        default:        gamma_en_q   <= gamma_en_q;
      endcase
    end
  end

  // Captured request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_ACC;
      inr_q <= 1'b0;
    end else if (accept) begin
      op_q  <= op_e'(s_axis_tuser_i);
      inr_q <= (RNG_W'(s_bin) < RNG_W'(BINS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= AW'(s_bin);
      pix_q  <= s_pix;
    end
  end

  // Read-modify-write of the addressed bin. The read of a new request coincides
  // with the write-back of the previous one, so a same-bin read takes the
  // written word from the forwarding register instead of the stale memory data.
  assign entry = fwd_q ? fwd_data_q : mem_rdata_q;
  assign cnt   = entry[COUNT_BITS-1:0];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sums[c]     = entry[COUNT_BITS + c * SUM_W +: SUM_W];
      pix_ch[c]   = pix_q[(NUM_CH - 1 - c) * CH_W +: CH_W];
      acc_sums[c] = sums[c] + SUM_W'(pix_ch[c]);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
    end else if (state_q == ST_MOD) begin
      if (op_q == OP_ACC) begin
        mem_we    = inr_q && (cnt != CNT_MAX);
        mem_wdata = {acc_sums[2], acc_sums[1], acc_sums[0], cnt + COUNT_BITS'(1)};
      end else begin
        mem_we    = inr_q;
      end
    end
  end

  assign mem_re    = accept;
  assign mem_raddr = AW'(s_bin);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= accept && mem_we && (mem_raddr == mem_waddr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= mem_wdata;
  end

  // Division of the averaged channels.
  assign div_start = (state_q == ST_MOD) && (op_q == OP_EMIT);

  slca_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sums),
    .den_i   (cnt),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      had_q <= inr_q && (cnt != '0);
    end
  end

  // Gamma (if enabled) and brightness, then division by 255 as (x + (x >> 8) + 1) >> 8,
  // which is exact over the 16-bit product range.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (gamma_en_q) begin
        prod_d[c] = PROD_W'(GAMMA_TABLE[quo[c]]) * PROD_W'(brightness_q);
      end else begin
        prod_d[c] = PROD_W'(quo[c]) * PROD_W'(brightness_q);
      end
      scaled[c] = CH_W'((RNG_W'(prod_q[c]) + RNG_W'(prod_q[c] >> CH_W) + RNG_W'(1)) >> CH_W);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SHADE) begin
      prod_q <= prod_d;
    end
  end

  // Output register.
  assign out_load = (state_q == ST_SCALE) && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= had_q ? {scaled[2], scaled[1], scaled[0]} : '0;
      m_tuser_q <= had_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == AW'(BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (op_q == OP_EMIT) begin
          state_d = ST_DIV;
        end else if (!accept) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SHADE;
        end
      end
      ST_SHADE: state_d = ST_SCALE;
      ST_SCALE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  a_no_write_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_SHADE || state_q == ST_SCALE) |-> !mem_we)
    else $error("bin store written while an emit is in flight");

  a_fwd_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (state_q == ST_MOD))
    else $error("forwarded word pending outside the modify cycle");

  a_scale_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE && m_valid_q && !m_axis_tready_i) |=> (state_q == ST_SCALE))
    else $error("result dropped while the output register was full");

  a_empty_is_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_tuser_q) |-> (m_tdata_q == '0))
    else $error("empty bin gave a non-black result");

endmodule
